// ----- src/assert_macros.svh -----
// assertion macros used by the checker file c39_checker
// no dependencies; take in with a plain include
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define C39_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define C39_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/c39_pkg.sv -----
// shared types, constants and the symbol match function of the code 39 decoder
// no dependencies; compiled first
package c39_pkg;

	localparam int C39_TIME_W    = 32;
	localparam int C39_THR_W     = 16;
	localparam int C39_CFG_IDX_W = 8;
	localparam int C39_PAT_W     = 9;
	localparam int C39_CHAR_W    = 7;
	localparam int C39_SYM_COUNT = 40;
	localparam int C39_FIFO_DEPTH = 4;
	localparam int C39_FIFO_PTR_W = $clog2(C39_FIFO_DEPTH);
	localparam int C39_FIFO_CNT_W = $clog2(C39_FIFO_DEPTH + 1);
	localparam int C39_CNT_W     = 4;

	// configuration register indexes
	localparam logic [C39_CFG_IDX_W-1:0] C39_CFG_NARROW_MIN = 8'd0;
	localparam logic [C39_CFG_IDX_W-1:0] C39_CFG_WIDE_MIN   = 8'd1;

	// reset values of the thresholds
	localparam logic [C39_THR_W-1:0] C39_NARROW_MIN_RST = 16'd300;
	localparam logic [C39_THR_W-1:0] C39_WIDE_MIN_RST   = 16'd600;

	// index of the element that completes a symbol
	localparam logic [C39_CNT_W-1:0] C39_LAST_ELEM = 4'd8;

	// one classified element between front and back
	typedef struct packed {
		logic valid;
		logic wide;
	} c39_elem_t;

	typedef struct packed {
		logic                  matched;
		logic [C39_CHAR_W-1:0] char_code;
	} c39_match_t;

	// standard code 39 wide-element patterns, first element in the msb
	localparam logic [C39_PAT_W-1:0] C39_SYM_PATTERN [C39_SYM_COUNT] = '{
		9'h109, 9'h049, 9'h148, 9'h019, 9'h118, 9'h058, 9'h00D, 9'h10C, 9'h04C, 9'h01C,
		9'h103, 9'h043, 9'h142, 9'h013, 9'h112, 9'h052, 9'h007, 9'h106, 9'h046, 9'h016,
		9'h181, 9'h0C1, 9'h1C0, 9'h091, 9'h190, 9'h0D0,
		9'h034, 9'h121, 9'h061, 9'h160, 9'h031, 9'h130, 9'h070, 9'h025, 9'h124, 9'h064,
		9'h085, 9'h184, 9'h0C4, 9'h094
	};

	// ascii of A..Z, 0..9, dash, period, space, star
	localparam logic [C39_CHAR_W-1:0] C39_SYM_ASCII [C39_SYM_COUNT] = '{
		7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46, 7'h47, 7'h48, 7'h49, 7'h4A,
		7'h4B, 7'h4C, 7'h4D, 7'h4E, 7'h4F, 7'h50, 7'h51, 7'h52, 7'h53, 7'h54,
		7'h55, 7'h56, 7'h57, 7'h58, 7'h59, 7'h5A,
		7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39,
		7'h2D, 7'h2E, 7'h20, 7'h2A
	};

	// parallel compare against all symbols; patterns are unique
	function automatic c39_match_t c39_match(input logic [C39_PAT_W-1:0] pat);
		c39_match_t res;
		res = '0;
		for (int k = 0; k < C39_SYM_COUNT; k++) begin
			if (C39_SYM_PATTERN[k] == pat) begin
				res.matched   = 1'b1;
				res.char_code = C39_SYM_ASCII[k];
			end
		end
		return res;
	endfunction

endpackage

// ----- src/c39_if.sv -----
// channel interfaces of the code 39 decoder: samples, results, configuration
// depends on c39_pkg
interface c39_sample_if;
	import c39_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  line_level;
	logic [C39_TIME_W-1:0] time_ms;
	modport source (output valid, line_level, time_ms, input ready);
	modport sink (input valid, line_level, time_ms, output ready);
endinterface

interface c39_result_if;
	import c39_pkg::*;
	logic                  valid;
	logic                  ready;
	logic                  matched;
	logic [C39_CHAR_W-1:0] char_code;
	logic [C39_PAT_W-1:0]  wide_pattern;
	modport source (output valid, matched, char_code, wide_pattern, input ready);
	modport sink (input valid, matched, char_code, wide_pattern, output ready);
endinterface

interface c39_cfg_if;
	import c39_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [C39_CFG_IDX_W-1:0] index;
	logic [C39_THR_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- src/c39_front.sv -----
// front end: edge detect, pulse width, element classification, threshold registers
// depends on c39_pkg and c39_if
module c39_front (
	input  logic               clk,
	input  logic               arst_n,
	c39_sample_if.sink         sample,
	c39_cfg_if.sink            cfg,
	input  logic               fifo_full,
	output c39_pkg::c39_elem_t push
);
	import c39_pkg::*;

	logic                  active_q;
	logic [C39_TIME_W-1:0] start_q;
	logic [C39_THR_W-1:0]  narrow_min_q;
	logic [C39_THR_W-1:0]  wide_min_q;
	logic                  accept;
	logic                  rise;
	logic                  fall;
	logic [C39_TIME_W-1:0] width;

	assign sample.ready = !fifo_full;
	assign cfg.ready    = 1'b1;
	assign accept       = sample.valid && sample.ready;

	// edge detect and width with 32-bit wrap
	always_comb begin
		rise  = sample.line_level && !active_q;
		fall  = !sample.line_level && active_q;
		width = sample.time_ms - start_q;
		push.valid = accept && fall
			&& (width > {{(C39_TIME_W-C39_THR_W){1'b0}}, narrow_min_q});
		push.wide  = width >= {{(C39_TIME_W-C39_THR_W){1'b0}}, wide_min_q};
	end

	// pulse tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			start_q  <= '0;
		end else if (accept) begin
			if (rise) begin
				active_q <= 1'b1;
				start_q  <= sample.time_ms;
			end else if (fall) begin
				active_q <= 1'b0;
			end
		end
	end

	// threshold registers; other indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			narrow_min_q <= C39_NARROW_MIN_RST;
			wide_min_q   <= C39_WIDE_MIN_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				C39_CFG_NARROW_MIN: narrow_min_q <= cfg.data;
				C39_CFG_WIDE_MIN:   wide_min_q   <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// ----- src/c39_fifo.sv -----
// short element queue between front and back
// depends on c39_pkg
module c39_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  c39_pkg::c39_elem_t push,
	input  logic               pop,
	output logic               full,
	output c39_pkg::c39_elem_t head
);
	import c39_pkg::*;

	logic                      mem_q [C39_FIFO_DEPTH];
	logic [C39_FIFO_PTR_W-1:0] wr_ptr_q;
	logic [C39_FIFO_PTR_W-1:0] rd_ptr_q;
	logic [C39_FIFO_CNT_W-1:0] count_q;
	logic                      do_pop;

	assign full       = count_q == C39_FIFO_CNT_W'(C39_FIFO_DEPTH);
	assign head.valid = count_q != '0;
	assign head.wide  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	// storage
	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.wide;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push.valid, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/c39_back.sv -----
// back end: pattern assembly, symbol match and result register
// depends on c39_pkg and c39_if
module c39_back (
	input  logic               clk,
	input  logic               arst_n,
	input  c39_pkg::c39_elem_t head,
	output logic               pop,
	c39_result_if.source       result
);
	import c39_pkg::*;

	logic [C39_CNT_W-1:0]  count_q;
	logic [C39_PAT_W-1:0]  pattern_q;
	logic                  out_valid_q;
	logic                  matched_q;
	logic [C39_CHAR_W-1:0] char_code_q;
	logic [C39_PAT_W-1:0]  wide_pattern_q;
	logic                  last;
	logic [C39_PAT_W-1:0]  pattern_next;
	c39_match_t            hit;

	assign result.valid        = out_valid_q;
	assign result.matched      = matched_q;
	assign result.char_code    = char_code_q;
	assign result.wide_pattern = wide_pattern_q;

	// take an element unless the ninth would hit a stalled result register
	always_comb begin
		last         = count_q == C39_LAST_ELEM;
		pop          = head.valid && !(last && out_valid_q && !result.ready);
		pattern_next = {pattern_q[C39_PAT_W-2:0], head.wide};
		hit          = c39_match(pattern_next);
	end

	// element count and pattern shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pattern_q <= '0;
		end else if (pop) begin
			if (last) begin
				count_q   <= '0;
				pattern_q <= '0;
			end else begin
				count_q   <= count_q + 1'b1;
				pattern_q <= pattern_next;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && last) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (pop && last) begin
			matched_q      <= hit.matched;
			char_code_q    <= hit.char_code;
			wide_pattern_q <= pattern_next;
		end
	end

endmodule

// ----- src/code39_pulse_width_decoder.sv -----
// top level of the code 39 pulse width decoder
// depends on c39_pkg, c39_if, c39_front, c39_fifo, c39_back
//
// sample channel: one word per scanner sample, line_level and a millisecond time_ms.
// a rising level starts a pulse; a falling level ends it and its width (time difference,
// 32-bit wrap) becomes an element when it exceeds narrow_min_ms, wide when it reaches
// wide_min_ms. every ninth element yields one result word.
// result channel: matched, char_code (ascii, 0 when unknown) and the nine-element
// wide_pattern, first element in bit 8.
// cfg channel: index 0 writes narrow_min_ms, index 1 writes wide_min_ms, other indexes
// are dropped; always ready. write only while the block is idle.
// throughput: one sample per cycle unless the queue is full; one subtract, two compares.
// path: the ninth element enters the queue, then the back end loads the result register.
// a four-word element queue separates front and back; when the receiver stalls, the
// result register holds, the back end stops at the next ninth element and the queue
// fills, after which sample ready drops.
// reset: thresholds return to 300 and 600 ms, pulse, pattern, count and queue clear.
module code39_pulse_width_decoder (
	input  logic         clk,
	input  logic         arst_n,
	c39_sample_if.sink   sample,
	c39_result_if.source result,
	c39_cfg_if.sink      cfg
);
	import c39_pkg::*;

	c39_elem_t push;
	c39_elem_t head;
	logic      fifo_full;
	logic      pop;

	// classify samples into elements
	c39_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample),
		.cfg       (cfg),
		.fifo_full (fifo_full),
		.push      (push)
	);

	// element queue
	c39_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (fifo_full),
		.head   (head)
	);

	// assemble and match symbols
	c39_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

// ----- src/c39_checker.sv -----
// port-level checks on the result channel of the code 39 decoder
// depends on assert_macros.svh; bound to code39_pulse_width_decoder
`include "assert_macros.svh"

module c39_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       out_matched,
	input logic [6:0] out_char_code,
	input logic [8:0] out_wide_pattern
);

	// a stalled result stays offered
	`C39_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// a stalled result word does not change
	`C39_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable({out_matched, out_char_code, out_wide_pattern}), "result word changed while stalled")

	// char code is nonzero exactly when matched
	`C39_ASSERT_NOW(a_char_flag, clk, arst_n, out_valid, out_matched == (out_char_code != 7'd0), "char code disagrees with match flag")

	// every code 39 symbol has three wide elements
	`C39_ASSERT_NOW(a_three_wide, clk, arst_n, out_valid && out_matched, $countones(out_wide_pattern) == 3, "matched pattern without three wide elements")

endmodule

bind code39_pulse_width_decoder c39_checker u_c39_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.out_matched      (result.matched),
	.out_char_code    (result.char_code),
	.out_wide_pattern (result.wide_pattern)
);
